// ----- hw/rtl/bea_pkg.sv -----
// Package of the band envelope bin analyzer: field widths, register map,
// filter stage codes, reset values and the sequencer state type.
// Has no dependencies; the interfaces, the analyzer and the testbench refer to it.
package bea_pkg;

  localparam int SMP_W   = 16;
  localparam int LEN_W   = 13;
  localparam int COEF_W  = 16;
  localparam int ST_W    = 24;
  localparam int SUM_W   = 44;
  localparam int MAG_W   = 16;
  localparam int SUB_W   = 3;
  localparam int CC_W    = 2;
  localparam int PR_W    = 4;
  localparam int STAGES  = 6;
  localparam int PADDR_W = 4;
  localparam int DATA_W  = 32;

  localparam logic [2:0] STG_LOW1  = 3'd0;
  localparam logic [2:0] STG_LOW2  = 3'd1;
  localparam logic [2:0] STG_MID1  = 3'd2;
  localparam logic [2:0] STG_MID2  = 3'd3;
  localparam logic [2:0] STG_HIGH1 = 3'd4;
  localparam logic [2:0] STG_HIGH2 = 3'd5;

  localparam logic [1:0] REG_LOW_COEF      = 2'd0;
  localparam logic [1:0] REG_HIGH_COEF     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_PEAK_RATIO    = 2'd3;

  localparam logic [1:0] SUM_OVERALL = 2'd0;
  localparam logic [1:0] SUM_BASS    = 2'd1;
  localparam logic [1:0] SUM_MID     = 2'd2;
  localparam logic [1:0] SUM_TREBLE  = 2'd3;

  localparam logic [COEF_W-1:0] LOW_COEF_RST  = 16'd3660;
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = 16'd23420;
  localparam logic [CC_W-1:0]   CH_COUNT_RST  = 2'd2;
  localparam logic [PR_W-1:0]   PEAK_RATIO_RST = 4'd4;

  localparam logic KIND_ENV  = 1'b0;
  localparam logic KIND_PEAK = 1'b1;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_RD     = 15'h0002,
    S_MUL    = 15'h0004,
    S_WR     = 15'h0008,
    S_CHDONE = 15'h0010,
    S_SQ     = 15'h0020,
    S_PB     = 15'h0040,
    S_SBRD   = 15'h0080,
    S_SBWR   = 15'h0100,
    S_END    = 15'h0200,
    S_DIV    = 15'h0400,
    S_SQRT   = 15'h0800,
    S_ENV    = 15'h1000,
    S_SUBRD  = 15'h2000,
    S_SUBOUT = 15'h4000
  } state_e;

endpackage

// ----- hw/rtl/bea_in_if.sv -----
// Input channel of the band envelope bin analyzer: one audio frame a request.
// Depends on bea_pkg for the field widths.
interface bea_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bea_pkg::SMP_W-1:0]  sample_ch0;
  logic signed [bea_pkg::SMP_W-1:0]  sample_ch1;
  logic        [bea_pkg::LEN_W-1:0]  bin_length;
  logic                              clear_filters;

  modport source (output valid, sample_ch0, sample_ch1, bin_length, clear_filters,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, bin_length, clear_filters,
                output ready);
endinterface

// ----- hw/rtl/bea_out_if.sv -----
// Result channel of the band envelope bin analyzer: one result a request.
// Depends on bea_pkg for the field widths.
interface bea_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic        [bea_pkg::SUB_W-1:0]  sub_index;
  logic signed [bea_pkg::SMP_W-1:0]  low_value;
  logic signed [bea_pkg::SMP_W-1:0]  high_value;
  logic        [bea_pkg::MAG_W-1:0]  peak_level;
  logic        [bea_pkg::MAG_W-1:0]  rms_level;
  logic        [bea_pkg::MAG_W-1:0]  bass_level;
  logic        [bea_pkg::MAG_W-1:0]  mid_level;
  logic        [bea_pkg::MAG_W-1:0]  treble_level;
  logic                              last_of_run;

  modport source (output valid, kind, sub_index, low_value, high_value, peak_level,
                  rms_level, bass_level, mid_level, treble_level, last_of_run,
                  input ready);
  modport sink (input valid, kind, sub_index, low_value, high_value, peak_level,
                rms_level, bass_level, mid_level, treble_level, last_of_run,
                output ready);
endinterface

// ----- hw/rtl/band_envelope_bin_analyzer.sv -----
// Band envelope bin analyzer. Each frame takes every filter stage of every channel
// through read, multiply and write back on the shared multiplier and filter RAM,
// then a sub-bin search if the peak ratio is nonzero. A bin's last frame adds a
// divide and a square root per sum, then the envelope and sub-bin results. One
// frame is in work at a time. Reset is asynchronous; filter and sub-bin entries
// read as zero until written (valid bits), so no clearing pass.
module band_envelope_bin_analyzer #(
  parameter int CHANNELS       = 2,
  parameter int MAX_BIN_LENGTH = 4096,
  parameter int MAX_PEAK_RATIO = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bea_pkg::PADDR_W-1:0]   paddr,
  input  logic [bea_pkg::DATA_W-1:0]    pwdata,
  output logic [bea_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  bea_in_if.sink                        in_if,
  bea_out_if.source                     out_if
);

  localparam int MAX_CH   = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FL_DEPTH = CHANNELS * bea_pkg::STAGES;
  localparam int FL_AW    = $clog2(FL_DEPTH);
  localparam int SB_AW    = (MAX_PEAK_RATIO > 1) ? $clog2(MAX_PEAK_RATIO) : 1;
  localparam int POS_W    = $clog2(MAX_BIN_LENGTH);
  localparam int ACC_W    = ((POS_W > bea_pkg::LEN_W) ? POS_W : bea_pkg::LEN_W)
                            + bea_pkg::PR_W;
  localparam int SW       = bea_pkg::SUM_W;
  localparam int LW       = bea_pkg::LEN_W;

  function automatic logic [15:0] band_mag(input logic signed [26:0] v);
    logic [26:0] a;
    a = v[26] ? 27'(-v) : 27'(v);
    return (|a[26:21]) ? 16'hFFFF : a[20:5];
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [16:0] t;
    t = v[15] ? 17'(-17'(v)) : 17'(v);
    return t[15:0];
  endfunction

  function automatic logic [15:0] peak_of(input logic signed [15:0] lo,
                                          input logic signed [15:0] hi);
    logic signed [16:0] nl;
    nl = -17'(lo);
    return (nl > 17'(hi)) ? nl[15:0] : hi[15:0];
  endfunction

  bea_pkg::state_e state_q, state_d;

  logic [bea_pkg::COEF_W-1:0] low_coef_q, high_coef_q;
  logic [bea_pkg::CC_W-1:0]   ch_count_q;
  logic [bea_pkg::PR_W-1:0]   peak_ratio_q;

  logic signed [15:0] smp0_q, smp1_q;
  logic               clr_q;
  logic [LW-1:0]      len_q;
  logic [1:0]         nch_q;
  logic [3:0]         ratio_q;
  logic [CH_W-1:0]    ch_q;
  logic [2:0]         stg_q;
  logic signed [bea_pkg::ST_W-1:0] st_q [bea_pkg::STAGES];
  logic signed [bea_pkg::ST_W-1:0] s_q;
  logic signed [42:0] prod_q;
  logic signed [15:0] speak_q;
  logic [15:0]        overall_q, bass_q, mid_q, treb_q;
  logic [SW-1:0]      sum_q [4];
  logic signed [15:0] lo_q, hi_q;
  logic [POS_W-1:0]   pos_q;
  logic [MAX_PEAK_RATIO-1:0] seen_q;
  logic [FL_DEPTH-1:0] fl_vld_q;
  logic [1:0]         k_q;
  logic [SB_AW-1:0]   pb_q, sbk_q;
  logic [3:0]         kk_q;
  logic [ACC_W-1:0]   acc_q;
  logic [LW:0]        rem_q;
  logic [SW-1:0]      quo_q, sq_v_q, sq_r_q, sq_bit_q;
  logic [5:0]         cnt_q;
  logic [15:0]        lvl_q [4];

  logic               out_valid_q, out_kind_q, out_last_q;
  logic [bea_pkg::SUB_W-1:0] out_sub_q;
  logic signed [15:0] out_lo_q, out_hi_q;
  logic [15:0]        out_pk_q, out_rms_q, out_bass_q, out_mid_q, out_treb_q;

  // Configuration port.
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_coef_q   <= bea_pkg::LOW_COEF_RST;
      high_coef_q  <= bea_pkg::HIGH_COEF_RST;
      ch_count_q   <= bea_pkg::CH_COUNT_RST;
      peak_ratio_q <= bea_pkg::PEAK_RATIO_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        bea_pkg::REG_LOW_COEF:      low_coef_q   <= pwdata[15:0];
        bea_pkg::REG_HIGH_COEF:     high_coef_q  <= pwdata[15:0];
        bea_pkg::REG_CHANNEL_COUNT: ch_count_q   <= pwdata[1:0];
        bea_pkg::REG_PEAK_RATIO:    peak_ratio_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bea_pkg::REG_LOW_COEF:      prdata = 32'(low_coef_q);
      bea_pkg::REG_HIGH_COEF:     prdata = 32'(high_coef_q);
      bea_pkg::REG_CHANNEL_COUNT: prdata = 32'(ch_count_q);
      bea_pkg::REG_PEAK_RATIO:    prdata = 32'(peak_ratio_q);
      default:                    prdata = '0;
    endcase
  end

  // Frame setup values.
  logic [LW-1:0] len_in;
  logic [1:0]    nch_in;
  logic [3:0]    ratio_in;
  always_comb begin
    len_in = in_if.bin_length;
    if (len_in == '0) begin
      len_in = LW'(1);
    end
    if (32'(in_if.bin_length) > MAX_BIN_LENGTH) begin
      len_in = LW'(MAX_BIN_LENGTH);
    end
    nch_in = (ch_count_q == 2'd0) ? 2'd1 : ch_count_q;
    if (32'(nch_in) > MAX_CH) begin
      nch_in = 2'(MAX_CH);
    end
    ratio_in = (32'(peak_ratio_q) > MAX_PEAK_RATIO) ? 4'(MAX_PEAK_RATIO) : peak_ratio_q;
  end

  // Filter datapath.
  logic [FL_AW-1:0]   fl_addr;
  logic               fl_we, active;
  logic [bea_pkg::ST_W-1:0] fl_rdata, fl_wdata;
  logic signed [15:0] cur_smp;
  logic signed [20:0] x_s;
  logic signed [25:0] stg_in, diff, new_wide;
  logic signed [bea_pkg::ST_W-1:0] fl_s, new_st;
  logic [bea_pkg::COEF_W-1:0] coef;
  logic signed [42:0] mul_s;
  logic signed [26:0] hp1, hp2, midv;
  logic [15:0] a_smp, a_speak, m_bass, m_mid, m_treb;

  assign fl_addr = FL_AW'(FL_AW'(ch_q) * FL_AW'(bea_pkg::STAGES)) + FL_AW'(stg_q);
  assign active  = 4'(ch_q) < 4'(nch_q);
  assign cur_smp = (ch_q == CH_W'(0)) ? smp0_q :
                   ((ch_q == CH_W'(1)) ? smp1_q : 16'sd0);
  assign x_s     = {cur_smp, 5'b0};

  always_comb begin
    case (stg_q)
      bea_pkg::STG_LOW1, bea_pkg::STG_MID1, bea_pkg::STG_HIGH1: stg_in = 26'(x_s);
      bea_pkg::STG_LOW2:  stg_in = 26'(st_q[bea_pkg::STG_LOW1]);
      bea_pkg::STG_MID2:  stg_in = 26'(st_q[bea_pkg::STG_MID1]);
      bea_pkg::STG_HIGH2: stg_in = 26'(x_s) - 26'(st_q[bea_pkg::STG_HIGH1]);
      default:            stg_in = '0;
    endcase
  end

  assign coef = (stg_q == bea_pkg::STG_LOW1 || stg_q == bea_pkg::STG_LOW2) ?
                low_coef_q : high_coef_q;
  assign fl_s = (clr_q || !fl_vld_q[fl_addr]) ? '0 : signed'(fl_rdata);
  assign diff = stg_in - 26'(fl_s);
  assign mul_s = 43'(diff) * 43'(signed'({1'b0, coef}));
  assign new_wide = 26'(s_q) + 26'(prod_q >>> 16);
  assign new_st = new_wide[bea_pkg::ST_W-1:0];
  assign fl_we = (state_q == bea_pkg::S_WR) && (active || clr_q);
  assign fl_wdata = active ? new_st : '0;

  assign hp1  = 27'(x_s) - 27'(st_q[bea_pkg::STG_HIGH1]);
  assign hp2  = hp1 - 27'(st_q[bea_pkg::STG_HIGH2]);
  assign midv = 27'(st_q[bea_pkg::STG_MID2]) - 27'(st_q[bea_pkg::STG_LOW2]);
  assign m_bass  = band_mag(27'(st_q[bea_pkg::STG_LOW2]));
  assign m_mid   = band_mag(midv);
  assign m_treb  = band_mag(hp2);
  assign a_smp   = abs16(cur_smp);
  assign a_speak = abs16(speak_q);

  bea_ram #(.WIDTH(bea_pkg::ST_W), .DEPTH(FL_DEPTH), .AW(FL_AW)) u_fl_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_addr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_addr),
    .rdata_o (fl_rdata)
  );

  // Bin statistics datapath.
  logic [15:0]   sq_m;
  logic [31:0]   sq_p;
  logic [SW:0]   sq_sum;
  logic [ACC_W-1:0] pos_ratio;
  logic [SB_AW-1:0] sb_raddr;
  logic          sb_we;
  logic [31:0]   sb_rdata, sb_wdata;
  logic signed [15:0] sb_lo, sb_hi;
  logic [LW:0]   div_t;
  logic          div_ge;
  logic [SW-1:0] quo_nx, sq_rb;
  logic          sq_fit;
  logic [SW-1:0] sq_r_nx;
  logic          out_free, out_load;

  always_comb begin
    case (k_q)
      bea_pkg::SUM_OVERALL: sq_m = overall_q;
      bea_pkg::SUM_BASS:    sq_m = bass_q;
      bea_pkg::SUM_MID:     sq_m = mid_q;
      bea_pkg::SUM_TREBLE:  sq_m = treb_q;
      default:              sq_m = '0;
    endcase
  end
  assign sq_p   = sq_m * sq_m;
  assign sq_sum = {1'b0, sum_q[k_q]} + (SW + 1)'(sq_p);

  assign pos_ratio = ACC_W'(ACC_W'(pos_q) * ACC_W'(ratio_q));
  assign sb_raddr  = (state_q == bea_pkg::S_SBRD || state_q == bea_pkg::S_SBWR) ?
                     pb_q : sbk_q;
  assign sb_we     = state_q == bea_pkg::S_SBWR;
  assign sb_lo     = signed'(sb_rdata[31:16]);
  assign sb_hi     = signed'(sb_rdata[15:0]);

  always_comb begin
    if (!seen_q[pb_q]) begin
      sb_wdata = {speak_q, speak_q};
    end else begin
      sb_wdata[31:16] = (speak_q < sb_lo) ? speak_q : sb_lo;
      sb_wdata[15:0]  = (speak_q > sb_hi) ? speak_q : sb_hi;
    end
  end

  bea_ram #(.WIDTH(32), .DEPTH(MAX_PEAK_RATIO), .AW(SB_AW)) u_sb_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (pb_q),
    .wdata_i (sb_wdata),
    .raddr_i (sb_raddr),
    .rdata_o (sb_rdata)
  );

  assign div_t   = {rem_q[LW-1:0], quo_q[SW-1]};
  assign div_ge  = div_t >= {1'b0, len_q};
  assign quo_nx  = {quo_q[SW-2:0], div_ge};
  assign sq_rb   = sq_r_q + sq_bit_q;
  assign sq_fit  = sq_v_q >= sq_rb;
  assign sq_r_nx = sq_fit ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

  assign out_free = !out_valid_q || out_if.ready;
  assign out_load = (state_q == bea_pkg::S_ENV || state_q == bea_pkg::S_SUBOUT) && out_free;
  assign in_if.ready = state_q == bea_pkg::S_IDLE;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bea_pkg::S_IDLE:   if (in_if.valid) state_d = bea_pkg::S_RD;
      bea_pkg::S_RD:     state_d = bea_pkg::S_MUL;
      bea_pkg::S_MUL:    state_d = bea_pkg::S_WR;
      bea_pkg::S_WR:     state_d = (stg_q == bea_pkg::STG_HIGH2) ? bea_pkg::S_CHDONE :
                                                                   bea_pkg::S_RD;
      bea_pkg::S_CHDONE: state_d = (ch_q == CH_W'(CHANNELS - 1)) ? bea_pkg::S_SQ :
                                                                   bea_pkg::S_RD;
      bea_pkg::S_SQ: begin
        if (k_q == bea_pkg::SUM_TREBLE) begin
          state_d = (ratio_q == 4'd0) ? bea_pkg::S_END : bea_pkg::S_PB;
        end
      end
      bea_pkg::S_PB: begin
        if (!(kk_q < ratio_q && pos_ratio >= acc_q)) state_d = bea_pkg::S_SBRD;
      end
      bea_pkg::S_SBRD:   state_d = bea_pkg::S_SBWR;
      bea_pkg::S_SBWR:   state_d = bea_pkg::S_END;
      bea_pkg::S_END: begin
        state_d = ((17'(pos_q) + 17'd1) < 17'(len_q)) ? bea_pkg::S_IDLE : bea_pkg::S_DIV;
      end
      bea_pkg::S_DIV:    if (cnt_q == 6'(SW - 1)) state_d = bea_pkg::S_SQRT;
      bea_pkg::S_SQRT: begin
        if (sq_bit_q[0]) begin
          state_d = (k_q == bea_pkg::SUM_TREBLE) ? bea_pkg::S_ENV : bea_pkg::S_DIV;
        end
      end
      bea_pkg::S_ENV: begin
        if (out_free) state_d = (ratio_q == 4'd0) ? bea_pkg::S_IDLE : bea_pkg::S_SUBRD;
      end
      bea_pkg::S_SUBRD:  state_d = bea_pkg::S_SUBOUT;
      bea_pkg::S_SUBOUT: begin
        if (out_free) begin
          state_d = (4'(sbk_q) == ratio_q - 4'd1) ? bea_pkg::S_IDLE : bea_pkg::S_SUBRD;
        end
      end
      default:           state_d = bea_pkg::S_IDLE;
    endcase
  end

  logic bin_done;
  assign bin_done = ((state_q == bea_pkg::S_ENV) && out_free && (ratio_q == 4'd0)) ||
                    ((state_q == bea_pkg::S_SUBOUT) && out_free &&
                     (4'(sbk_q) == ratio_q - 4'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bea_pkg::S_IDLE;
      fl_vld_q    <= '0;
      seen_q      <= '0;
      pos_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      for (int i = 0; i < 4; i++) sum_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fl_we) begin
        fl_vld_q[fl_addr] <= 1'b1;
      end
      if (state_q == bea_pkg::S_SQ) begin
        sum_q[k_q] <= sq_sum[SW] ? {SW{1'b1}} : sq_sum[SW-1:0];
        if (k_q == bea_pkg::SUM_OVERALL) begin
          if (pos_q == '0) begin
            lo_q <= speak_q;
            hi_q <= speak_q;
          end else begin
            if (speak_q < lo_q) lo_q <= speak_q;
            if (speak_q > hi_q) hi_q <= speak_q;
          end
        end
      end
      if (sb_we) begin
        seen_q[pb_q] <= 1'b1;
      end
      if (state_q == bea_pkg::S_END && state_d == bea_pkg::S_IDLE) begin
        pos_q <= pos_q + 1'b1;
      end
      if (bin_done) begin
        for (int i = 0; i < 4; i++) sum_q[i] <= '0;
        lo_q   <= '0;
        hi_q   <= '0;
        pos_q  <= '0;
        seen_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bea_pkg::S_IDLE: begin
        smp0_q    <= in_if.sample_ch0;
        smp1_q    <= in_if.sample_ch1;
        clr_q     <= in_if.clear_filters;
        len_q     <= len_in;
        nch_q     <= nch_in;
        ratio_q   <= ratio_in;
        ch_q      <= '0;
        stg_q     <= bea_pkg::STG_LOW1;
        speak_q   <= '0;
        overall_q <= '0;
        bass_q    <= '0;
        mid_q     <= '0;
        treb_q    <= '0;
      end
      bea_pkg::S_MUL: begin
        s_q    <= fl_s;
        prod_q <= mul_s;
      end
      bea_pkg::S_WR: begin
        st_q[stg_q] <= new_st;
        if (stg_q != bea_pkg::STG_HIGH2) stg_q <= stg_q + 3'd1;
      end
      bea_pkg::S_CHDONE: begin
        if (active) begin
          if (a_smp > a_speak)   speak_q   <= cur_smp;
          if (a_smp > overall_q) overall_q <= a_smp;
          if (m_bass > bass_q)   bass_q    <= m_bass;
          if (m_mid > mid_q)     mid_q     <= m_mid;
          if (m_treb > treb_q)   treb_q    <= m_treb;
        end
        ch_q  <= ch_q + 1'b1;
        stg_q <= bea_pkg::STG_LOW1;
        k_q   <= bea_pkg::SUM_OVERALL;
      end
      bea_pkg::S_SQ: begin
        k_q   <= k_q + 2'd1;
        pb_q  <= '0;
        kk_q  <= 4'd1;
        acc_q <= ACC_W'(len_q);
      end
      bea_pkg::S_PB: begin
        if (kk_q < ratio_q && pos_ratio >= acc_q) begin
          pb_q  <= pb_q + 1'b1;
          kk_q  <= kk_q + 4'd1;
          acc_q <= acc_q + ACC_W'(len_q);
        end
      end
      bea_pkg::S_END: begin
        k_q   <= bea_pkg::SUM_OVERALL;
        quo_q <= sum_q[bea_pkg::SUM_OVERALL];
        rem_q <= '0;
        cnt_q <= '0;
      end
      bea_pkg::S_DIV: begin
        rem_q <= div_ge ? (div_t - {1'b0, len_q}) : div_t;
        quo_q <= quo_nx;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(SW - 1)) begin
          sq_v_q   <= quo_nx;
          sq_r_q   <= '0;
          sq_bit_q <= SW'(1) << (SW - 2);
        end
      end
      bea_pkg::S_SQRT: begin
        if (sq_fit) sq_v_q <= sq_v_q - sq_rb;
        sq_r_q   <= sq_r_nx;
        sq_bit_q <= sq_bit_q >> 2;
        if (sq_bit_q[0]) begin
          lvl_q[k_q] <= sq_r_nx[15:0];
          k_q   <= k_q + 2'd1;
          quo_q <= sum_q[k_q + 2'd1];
          rem_q <= '0;
          cnt_q <= '0;
        end
      end
      bea_pkg::S_ENV: begin
        sbk_q <= '0;
      end
      bea_pkg::S_SUBOUT: begin
        if (out_free) sbk_q <= sbk_q + 1'b1;
      end
      default: ;
    endcase

    if (out_load) begin
      if (state_q == bea_pkg::S_ENV) begin
        out_kind_q <= bea_pkg::KIND_ENV;
        out_sub_q  <= '0;
        out_lo_q   <= lo_q;
        out_hi_q   <= hi_q;
        out_pk_q   <= peak_of(lo_q, hi_q);
        out_rms_q  <= lvl_q[bea_pkg::SUM_OVERALL];
        out_bass_q <= lvl_q[bea_pkg::SUM_BASS];
        out_mid_q  <= lvl_q[bea_pkg::SUM_MID];
        out_treb_q <= lvl_q[bea_pkg::SUM_TREBLE];
        out_last_q <= ratio_q == 4'd0;
      end else begin
        out_kind_q <= bea_pkg::KIND_PEAK;
        out_sub_q  <= bea_pkg::SUB_W'(sbk_q);
        out_lo_q   <= seen_q[sbk_q] ? sb_lo : 16'sd0;
        out_hi_q   <= seen_q[sbk_q] ? sb_hi : 16'sd0;
        out_pk_q   <= seen_q[sbk_q] ? peak_of(sb_lo, sb_hi) : 16'd0;
        out_rms_q  <= '0;
        out_bass_q <= '0;
        out_mid_q  <= '0;
        out_treb_q <= '0;
        out_last_q <= 4'(sbk_q) == ratio_q - 4'd1;
      end
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.kind         = out_kind_q;
  assign out_if.sub_index    = out_sub_q;
  assign out_if.low_value    = out_lo_q;
  assign out_if.high_value   = out_hi_q;
  assign out_if.peak_level   = out_pk_q;
  assign out_if.rms_level    = out_rms_q;
  assign out_if.bass_level   = out_bass_q;
  assign out_if.mid_level    = out_mid_q;
  assign out_if.treble_level = out_treb_q;
  assign out_if.last_of_run  = out_last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten while still pending");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == bea_pkg::KIND_PEAK) |-> (4'(out_sub_q) < ratio_q))
    else $error("sub-bin result beyond the peak ratio");

  a_pb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bea_pkg::S_SBWR) |-> (4'(pb_q) < ratio_q))
    else $error("sub-bin index beyond the peak ratio");

  a_env_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == bea_pkg::KIND_ENV && out_last_q) |-> (ratio_q == 4'd0))
    else $error("envelope result closed a bin that has sub-bin results");

endmodule

// ----- hw/rtl/bea_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- dv/tb_band_envelope_bin_analyzer.sv -----
// Testbench of the band envelope bin analyzer: predicts every envelope and peak
// sub-bin result from the accepted frames and register writes, and checks them.
// Depends on bea_pkg, bea_in_if, bea_out_if and the band_envelope_bin_analyzer RTL.
`timescale 1ns / 100ps

module tb_band_envelope_bin_analyzer;

  localparam int NCH = 2;
  localparam int MAXLEN = 4096;
  localparam int MAXRATIO = 8;
  localparam logic [43:0] SUM_SAT = '1;

  typedef struct packed {
    logic                       kind;
    logic [bea_pkg::SUB_W-1:0]  sub_index;
    logic [bea_pkg::SMP_W-1:0]  low_value;
    logic [bea_pkg::SMP_W-1:0]  high_value;
    logic [bea_pkg::MAG_W-1:0]  peak_level;
    logic [bea_pkg::MAG_W-1:0]  rms_level;
    logic [bea_pkg::MAG_W-1:0]  bass_level;
    logic [bea_pkg::MAG_W-1:0]  mid_level;
    logic [bea_pkg::MAG_W-1:0]  treble_level;
    logic                       last_of_run;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bea_pkg::PADDR_W-1:0] paddr = '0;
  logic [bea_pkg::DATA_W-1:0] pwdata = '0;
  logic [bea_pkg::DATA_W-1:0] prdata;
  logic pready;

  bea_in_if in_if ();
  bea_out_if out_if ();

  band_envelope_bin_analyzer dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  int unsigned low_coef_q, high_coef_q, chan_count_q, peak_ratio_q;
  longint low1 [NCH], low2 [NCH], mid1 [NCH], mid2 [NCH], hi1 [NCH], hi2 [NCH];
  logic [43:0] sq_sum [4];
  int bin_lo, bin_hi, sub_lo [MAXRATIO], sub_hi [MAXRATIO];
  int unsigned bin_pos;
  logic [7:0] sub_seen;

  result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0, recv_hold = 0;

  function automatic longint floor_div16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint pole_step(longint s, longint x, int unsigned c);
    return s + floor_div16((x - s) * longint'(c));
  endfunction

  function automatic int unsigned band_level(longint v);
    longint m;
    m = (v < 0 ? -v : v) >> 5;
    return m > 65535 ? 65535 : int'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_t make_result(logic kind, int sub, int lo, int hi,
      longint unsigned rms, longint unsigned bass, longint unsigned mid,
      longint unsigned treb, logic last);
    result_t r;
    r.kind = kind;
    r.sub_index = sub[bea_pkg::SUB_W-1:0];
    r.low_value = lo[15:0];
    r.high_value = hi[15:0];
    r.peak_level = (-lo > hi) ? 16'(-lo) : 16'(hi);
    r.rms_level = rms[15:0];
    r.bass_level = bass[15:0];
    r.mid_level = mid[15:0];
    r.treble_level = treb[15:0];
    r.last_of_run = last;
    return r;
  endfunction

  function automatic void expect_result(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_bin();
    foreach (sq_sum[k]) sq_sum[k] = '0;
    bin_lo = 0; bin_hi = 0; bin_pos = 0; sub_seen = '0;
    foreach (sub_lo[k]) begin
      sub_lo[k] = 0; sub_hi[k] = 0;
    end
  endfunction

  function automatic void clear_filters_model();
    for (int c = 0; c < NCH; c++) begin
      low1[c] = 0; low2[c] = 0; mid1[c] = 0; mid2[c] = 0; hi1[c] = 0; hi2[c] = 0;
    end
  endfunction

  function automatic void add_sq(int k, int unsigned m);
    logic [44:0] s;
    s = {1'b0, sq_sum[k]} + 45'(longint'(m) * m);
    sq_sum[k] = s > {1'b0, SUM_SAT} ? SUM_SAT : s[43:0];
  endfunction

  function automatic void predict_frame(logic signed [15:0] s0, logic signed [15:0] s1,
      logic [12:0] blen, logic clr);
    int unsigned nch, len, ratio, overall, bb, bm, bt, a, sp, m, pb;
    int speak, smp;
    longint x, hp1, hp2;
    nch = chan_count_q == 0 ? 1 : chan_count_q;
    if (nch > NCH) nch = NCH;
    len = blen == 0 ? 1 : blen;
    if (len > MAXLEN) len = MAXLEN;
    ratio = peak_ratio_q > MAXRATIO ? MAXRATIO : peak_ratio_q;
    overall = 0; bb = 0; bm = 0; bt = 0; speak = 0;
    if (clr) clear_filters_model();
    for (int c = 0; c < nch; c++) begin
      smp = (c == 0) ? s0 : s1;
      x = smp * 32;
      a = smp < 0 ? -smp : smp;
      sp = speak < 0 ? -speak : speak;
      if (a > sp) speak = smp;
      if (a > overall) overall = a;
      low1[c] = pole_step(low1[c], x, low_coef_q);
      low2[c] = pole_step(low2[c], low1[c], low_coef_q);
      mid1[c] = pole_step(mid1[c], x, high_coef_q);
      mid2[c] = pole_step(mid2[c], mid1[c], high_coef_q);
      hi1[c] = pole_step(hi1[c], x, high_coef_q);
      hp1 = x - hi1[c];
      hi2[c] = pole_step(hi2[c], hp1, high_coef_q);
      hp2 = hp1 - hi2[c];
      m = band_level(low2[c]); if (m > bb) bb = m;
      m = band_level(mid2[c] - low2[c]); if (m > bm) bm = m;
      m = band_level(hp2); if (m > bt) bt = m;
    end
    if (bin_pos == 0) begin
      bin_lo = speak; bin_hi = speak;
    end else begin
      if (speak < bin_lo) bin_lo = speak;
      if (speak > bin_hi) bin_hi = speak;
    end
    add_sq(bea_pkg::SUM_OVERALL, overall);
    add_sq(bea_pkg::SUM_BASS, bb);
    add_sq(bea_pkg::SUM_MID, bm);
    add_sq(bea_pkg::SUM_TREBLE, bt);
    if (ratio > 0) begin
      pb = (bin_pos * ratio) / len;
      if (pb > ratio - 1) pb = ratio - 1;
      if (!sub_seen[pb]) begin
        sub_lo[pb] = speak; sub_hi[pb] = speak; sub_seen[pb] = 1'b1;
      end else begin
        if (speak < sub_lo[pb]) sub_lo[pb] = speak;
        if (speak > sub_hi[pb]) sub_hi[pb] = speak;
      end
    end
    if (bin_pos + 1 < len) begin
      bin_pos++;
      return;
    end
    expect_result(make_result(bea_pkg::KIND_ENV, 0, bin_lo, bin_hi,
        int_sqrt(sq_sum[0] / len), int_sqrt(sq_sum[1] / len),
        int_sqrt(sq_sum[2] / len), int_sqrt(sq_sum[3] / len), ratio == 0));
    for (int k = 0; k < ratio; k++)
      expect_result(make_result(bea_pkg::KIND_PEAK, k, sub_lo[k], sub_hi[k],
          0, 0, 0, 0, k == ratio - 1));
    clear_bin();
  endfunction

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bea_pkg::PADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bea_pkg::REG_LOW_COEF:      low_coef_q = value & 16'hFFFF;
      bea_pkg::REG_HIGH_COEF:     high_coef_q = value & 16'hFFFF;
      bea_pkg::REG_CHANNEL_COUNT: chan_count_q = value & 3;
      bea_pkg::REG_PEAK_RATIO:    peak_ratio_q = value & 15;
      default: ;
    endcase
  endtask

  task automatic send_frame(logic signed [15:0] s0, logic signed [15:0] s1,
      logic [12:0] blen, logic clr);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.sample_ch0 <= s0;
    in_if.sample_ch1 <= s1;
    in_if.bin_length <= blen;
    in_if.clear_filters <= clr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_frame(s0, s1, blen, clr);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic random_bin(int unsigned len);
    for (int i = 0; i < len; i++)
      send_frame(16'($urandom), 16'($urandom), 13'(len), $urandom_range(30) == 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.sub_index, out_if.low_value, out_if.high_value,
             out_if.peak_level, out_if.rms_level, out_if.bass_level, out_if.mid_level,
             out_if.treble_level, out_if.last_of_run};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: expected %p", $time, exp_r);
          $display("%0t: actual   %p", $time, got);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_frame(16'sh7FFF, 16'sh8000, 13'd4, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 13'd4, 1'b0);
    send_frame(16'sh0000, 16'shFFFF, 13'd4, 1'b1);
    send_frame(16'sh0001, 16'sh0000, 13'd4, 1'b0);
    send_frame(16'sh1234, 16'shEDCC, 13'd0, 1'b0);
    send_frame(16'sh5555, 16'shAAAA, 13'd2, 1'b0);
    send_frame(16'sh2AAA, 16'sh5555, 13'd1, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 13'd6, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 13'd6, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 13'd2, 1'b0);
    send_frame(16'sh0100, 16'sh0200, 13'd5000, 1'b0);
    send_frame(16'sh0300, 16'sh0400, 13'd8191, 1'b0);
    send_frame(16'sh0300, 16'sh0400, 13'd1, 1'b1);
    drain();
  endtask

  task automatic test_configs();
    int unsigned cc [4] = '{1, 2, 0, 3};
    int unsigned pr [6] = '{0, 1, 8, 15, 3, 7};
    int unsigned co [4] = '{0, 65535, 1, 32768};
    for (int i = 0; i < 4; i++) begin
      write_reg(bea_pkg::REG_LOW_COEF, co[i]);
      write_reg(bea_pkg::REG_HIGH_COEF, co[3 - i]);
      write_reg(bea_pkg::REG_CHANNEL_COUNT, cc[i]);
      write_reg(bea_pkg::REG_PEAK_RATIO, pr[i]);
      random_bin($urandom_range(1, 10));
      random_bin(2);
      drain();
    end
    write_reg(bea_pkg::REG_PEAK_RATIO, pr[4]);
    write_reg(bea_pkg::REG_CHANNEL_COUNT, 2);
    random_bin(2);
    drain();
    write_reg(bea_pkg::REG_PEAK_RATIO, pr[5]);
    write_reg(bea_pkg::REG_LOW_COEF, 3660);
    write_reg(bea_pkg::REG_HIGH_COEF, 23420);
    random_bin(5);
    drain();
  endtask

  task automatic test_random(int unsigned frames);
    int unsigned sent;
    sent = 0;
    while (sent < frames) begin
      int unsigned len;
      len = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
      random_bin(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure();
    recv_hold = 2000;
    random_bin(1);
    random_bin(1);
    random_bin(3);
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_ch0 = '0;
    in_if.sample_ch1 = '0;
    in_if.bin_length = 13'd1;
    in_if.clear_filters = 1'b0;
    low_coef_q = bea_pkg::LOW_COEF_RST; high_coef_q = bea_pkg::HIGH_COEF_RST;
    chan_count_q = bea_pkg::CH_COUNT_RST; peak_ratio_q = bea_pkg::PEAK_RATIO_RST;
    clear_filters_model();
    clear_bin();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 12; recv_idle_pct = 47;
    test_directed();
    test_configs();
    test_random(70);
    send_idle_pct = 47; recv_idle_pct = 12;
    test_random(60);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(50);
    test_backpressure();
    if (errors == 0) begin
      $display("band_envelope_bin_analyzer: match");
    end else begin
      $display("band_envelope_bin_analyzer: mismatch");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("band_envelope_bin_analyzer: mismatch");
    $finish;
  end

endmodule

// ----- band_envelope_bin_analyzer.f -----
hw/rtl/bea_pkg.sv
hw/rtl/bea_in_if.sv
hw/rtl/bea_out_if.sv
hw/rtl/bea_ram.sv
hw/rtl/band_envelope_bin_analyzer.sv
dv/tb_band_envelope_bin_analyzer.sv
